@@ rtl/tcs_pkg.sv @@
package tcs_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int MOVE_CELLS = CELLS - COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);

  // Field widths
  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'd7;
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'd1824;

  typedef enum logic [OP_W-1:0] {
    OP_PRINT      = 3'd0,
    OP_NEWLINE    = 3'd1,
    OP_BACKSPACE  = 3'd2,
    OP_FILL       = 3'd3,
    OP_SET_CURSOR = 3'd4,
    OP_READ_CELL  = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_ATTR  = 1'b0,
    CFG_BLANK_CELL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  target_row;
    logic [COL_W-1:0]  target_col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RWAIT,
    S_BSWR,
    S_FILL,
    S_SCROLL_MOVE,
    S_SCROLL_BLANK,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_NL,
    CUR_BS,
    CUR_SET
  } cur_cmd_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_INC
  } cnt_cmd_t;

  typedef enum logic [2:0] {
    W_ZERO,
    W_CHAR,
    W_RESTORE,
    W_SPACE,
    W_MOVE,
    W_BLANK
  } wsel_t;

  typedef enum logic [1:0] {
    A_CURSOR,
    A_CNT,
    A_CNT_M1
  } wa_sel_t;

  typedef enum logic [1:0] {
    R_CURSOR,
    R_TARGET,
    R_CNT_COL
  } ra_sel_t;

  typedef struct packed {
    logic     load_item;
    cur_cmd_t cur_op;
    cnt_cmd_t cnt_op;
    logic     mem_we;
    wsel_t    wsel;
    wa_sel_t  wa_sel;
    ra_sel_t  ra_sel;
    logic     capture;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            at_last_col;
    logic            at_last_row;
    logic            col_zero;
    logic            row_zero;
    logic            target_ok;
    logic            cnt_zero;
    logic            cnt_last;
    logic            cnt_move_end;
    logic            out_free;
  } stat_t;

  // Linear cell address of a screen position
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    return a;
  endfunction

endpackage

@@ rtl/tcs_ram.sv @@
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tcs_ctrl.sv @@
module tcs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tcs_pkg::stat_t stat,
  output tcs_pkg::cmd_t  cmd
);
  import tcs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold the state register; start with the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Sequence each request through the datapath
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.cur_op    = CUR_HOLD;
    cmd.cnt_op    = CNT_HOLD;
    cmd.wsel      = W_ZERO;
    cmd.wa_sel    = A_CURSOR;
    cmd.ra_sel    = R_CURSOR;
    case (state_r)
      S_CLEAR: begin
        cmd.mem_we = 1'b1;
        cmd.wa_sel = A_CNT;
        cmd.wsel   = W_ZERO;
        if (stat.cnt_last) begin
          cmd.cnt_op = CNT_CLR;
          state_nxt  = S_IDLE;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_PRINT: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = W_CHAR;
            cmd.cur_op = CUR_ADV;
            if (stat.at_last_col && stat.at_last_row) begin
              cmd.cnt_op = CNT_CLR;
              state_nxt  = S_SCROLL_MOVE;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_NEWLINE, OP_BACKSPACE: begin
            cmd.ra_sel = R_CURSOR;
            state_nxt  = S_RWAIT;
          end
          OP_FILL: begin
            cmd.cnt_op = CNT_CLR;
            state_nxt  = S_FILL;
          end
          OP_SET_CURSOR: begin
            cmd.cur_op = CUR_SET;
            state_nxt  = S_DONE;
          end
          OP_READ_CELL: begin
            cmd.ra_sel = R_TARGET;
            state_nxt  = stat.target_ok ? S_RWAIT : S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RWAIT: begin
        case (stat.op)
          OP_READ_CELL: begin
            cmd.capture = 1'b1;
            state_nxt   = S_DONE;
          end
          OP_NEWLINE: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = W_RESTORE;
            cmd.cur_op = CUR_NL;
            if (stat.at_last_row) begin
              cmd.cnt_op = CNT_CLR;
              state_nxt  = S_SCROLL_MOVE;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_BACKSPACE: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = W_RESTORE;
            cmd.cur_op = CUR_BS;
            if (stat.col_zero && stat.row_zero) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_BSWR;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_BSWR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = W_SPACE;
        state_nxt  = S_DONE;
      end
      S_FILL: begin
        cmd.mem_we = 1'b1;
        cmd.wa_sel = A_CNT;
        cmd.wsel   = W_CHAR;
        if (stat.cnt_last) begin
          cmd.cnt_op = CNT_CLR;
          state_nxt  = S_DONE;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_SCROLL_MOVE: begin
        // Read one line ahead, write the cell fetched in the previous cycle
        cmd.ra_sel = R_CNT_COL;
        cmd.mem_we = !stat.cnt_zero;
        cmd.wa_sel = A_CNT_M1;
        cmd.wsel   = W_MOVE;
        if (stat.cnt_move_end) begin
          state_nxt = S_SCROLL_BLANK;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_SCROLL_BLANK: begin
        cmd.mem_we = 1'b1;
        cmd.wa_sel = A_CNT;
        cmd.wsel   = W_BLANK;
        if (stat.cnt_last) begin
          cmd.cnt_op = CNT_CLR;
          state_nxt  = S_DONE;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted request did not start execution");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd.mem_we)
    else $error("memory written while idle");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending result");

  a_move_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL_MOVE && state_nxt == S_SCROLL_BLANK) |-> stat.cnt_move_end)
    else $error("scroll move left early");
`endif

endmodule

@@ rtl/tcs_dpath.sv @@
module tcs_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcs_pkg::in_item_t                   in_item,
  input  logic                                out_stall,
  output logic                                out_valid,
  output tcs_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  tcs_pkg::cmd_t                       cmd,
  output tcs_pkg::stat_t                      stat
);
  import tcs_pkg::*;

  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ROW_W-1:0]  trow_r;
  logic [COL_W-1:0]  tcol_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [CELL_W-1:0] blank_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [CELL_W-1:0] data_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] tgt_addr;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rdata;

  assign cur_addr = cell_addr(row_r, col_r);
  assign tgt_addr = cell_addr(trow_r, tcol_r);

  // Latch the request fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_item.op;
      ch_r   <= in_item.char_code;
      trow_r <= in_item.target_row;
      tcol_r <= in_item.target_col;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r  <= ATTR_RESET;
      blank_r <= BLANK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_ATTR:  attr_r  <= cfg_wdata[ATTR_W-1:0];
        CFG_BLANK_CELL: blank_r <= cfg_wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Cursor update
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    case (cmd.cur_op)
      CUR_ADV: begin
        if (col_r == LAST_COL) begin
          col_nxt = '0;
          if (row_r != LAST_ROW) row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      CUR_NL: begin
        col_nxt = '0;
        if (row_r != LAST_ROW) row_nxt = row_r + 1'b1;
      end
      CUR_BS: begin
        if (col_r != '0) begin
          col_nxt = col_r - 1'b1;
        end else if (row_r != '0) begin
          row_nxt = row_r - 1'b1;
          col_nxt = LAST_COL;
        end
      end
      CUR_SET: begin
        row_nxt = (trow_r > LAST_ROW) ? LAST_ROW : trow_r;
        col_nxt = (tcol_r > LAST_COL) ? LAST_COL : tcol_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Sweep counter for clear, fill and scroll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_CLR: cnt_r <= '0;
        CNT_INC: cnt_r <= cnt_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Memory address and data selection
  always_comb begin
    case (cmd.wa_sel)
      A_CNT:    waddr = cnt_r;
      A_CNT_M1: waddr = cnt_r - 1'b1;
      default:  waddr = cur_addr;
    endcase
    case (cmd.ra_sel)
      R_TARGET:  raddr = tgt_addr;
      R_CNT_COL: raddr = cnt_r + ADDR_W'(COLUMNS);
      default:   raddr = cur_addr;
    endcase
    case (cmd.wsel)
      W_CHAR:    wdata = {attr_r, ch_r};
      W_RESTORE: wdata = {attr_r, rdata[CHAR_W-1:0]};
      W_SPACE:   wdata = {attr_r, SPACE_CHAR};
      W_MOVE:    wdata = rdata;
      W_BLANK:   wdata = blank_r;
      default:   wdata = '0;
    endcase
  end

  tcs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read data for the read-cell request, zero otherwise
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      data_r <= '0;
    end else if (cmd.capture) begin
      data_r <= rdata;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item_r.cursor_row <= row_r;
      out_item_r.cursor_col <= col_r;
      out_item_r.cell_data  <= data_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Status toward the controller
  always_comb begin
    stat.op           = op_r;
    stat.at_last_col  = (col_r == LAST_COL);
    stat.at_last_row  = (row_r == LAST_ROW);
    stat.col_zero     = (col_r == '0);
    stat.row_zero     = (row_r == '0);
    stat.target_ok    = (trow_r <= LAST_ROW) && (tcol_r <= LAST_COL);
    stat.cnt_zero     = (cnt_r == '0);
    stat.cnt_last     = (cnt_r == ADDR_W'(CELLS - 1));
    stat.cnt_move_end = (cnt_r == ADDR_W'(MOVE_CELLS));
    stat.out_free     = !out_valid_r || !out_stall;
  end

endmodule

@@ rtl/text_console_cursor_scroll_top.sv @@
// Text-mode console engine: an 80 x 25 screen of 16-bit cells and a cursor.
// Input channel (in_valid / in_stall / in_item) takes one request at a time:
// print, newline, backspace, fill, set cursor or read cell. Each request
// gives one result on the output channel (out_valid / out_stall / out_item)
// with the cursor after the request and, for read cell, the cell value.
// Print, set cursor and unused codes finish in the execute step; newline
// and read cell first read the cell (an out-of-range read skips the read),
// and backspace also writes a space after it (not at the top-left corner).
// A print or newline that scrolls moves one cell per cycle through the
// single screen RAM, then one blank cell per cycle; fill writes every cell.
// The next request is taken in the cycle after the result is loaded.
// After reset a pass clears all 2000 screen RAM cells to zero;
// in_stall stays high during it. Configuration writes (cfg_we, cfg_index,
// cfg_wdata) take effect at once and are meant for idle periods.
// If the receiver stalls, the result holds in the output register; one
// further request may be accepted and worked, then waits for the slot.
module text_console_cursor_scroll_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tcs_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcs_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ verif/tcs_console_check.sv @@
`timescale 1ns / 100ps

module tcs_console_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  tcs_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  tcs_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import tcs_pkg::*;

  // Shadow copy of the console: screen, cursor and both registers
  logic [CELL_W-1:0] screen_mem [CELLS];
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [ATTR_W-1:0] attr_q;
  logic [CELL_W-1:0] blank_q;
  out_item_t         awaited_results [$];
  int                fails;

  function automatic int screen_index(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    return int'(r) * COLUMNS + int'(c);
  endfunction

  function automatic logic [CELL_W-1:0] attr_cell(input logic [CHAR_W-1:0] ch);
    return {attr_q, ch};
  endfunction

  // Shift every line up by one and blank the new bottom line
  function automatic void scroll_screen();
    int i;
    for (i = 0; i < MOVE_CELLS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
    for (i = MOVE_CELLS; i < CELLS; i++) screen_mem[i] = blank_q;
  endfunction

  // Apply one request to the shadow console and return the result it gives
  function automatic out_item_t console_step(input in_item_t rq);
    out_item_t res;
    int        k;
    res = '0;
    k = screen_index(row_q, col_q);
    case (rq.op)
      OP_PRINT: begin
        screen_mem[k] = attr_cell(rq.char_code);
        if (col_q == LAST_COL) begin
          col_q = '0;
          if (row_q == LAST_ROW) scroll_screen();
          else row_q = row_q + 1'b1;
        end else begin
          col_q = col_q + 1'b1;
        end
      end
      OP_NEWLINE: begin
        screen_mem[k] = attr_cell(screen_mem[k][CHAR_W-1:0]);
        if (row_q == LAST_ROW) scroll_screen();
        else row_q = row_q + 1'b1;
        col_q = '0;
      end
      OP_BACKSPACE: begin
        // restore first; at the top-left corner nothing else happens
        screen_mem[k] = attr_cell(screen_mem[k][CHAR_W-1:0]);
        if (col_q != '0) begin
          col_q = col_q - 1'b1;
          screen_mem[screen_index(row_q, col_q)] = attr_cell(SPACE_CHAR);
        end else if (row_q != '0) begin
          row_q = row_q - 1'b1;
          col_q = LAST_COL;
          screen_mem[screen_index(row_q, col_q)] = attr_cell(SPACE_CHAR);
        end
      end
      OP_FILL: begin
        for (k = 0; k < CELLS; k++) screen_mem[k] = attr_cell(rq.char_code);
      end
      OP_SET_CURSOR: begin
        row_q = (rq.target_row > LAST_ROW) ? LAST_ROW : rq.target_row;
        col_q = (rq.target_col > LAST_COL) ? LAST_COL : rq.target_col;
      end
      OP_READ_CELL: begin
        if (rq.target_row <= LAST_ROW && rq.target_col <= LAST_COL)
          res.cell_data = screen_mem[screen_index(rq.target_row, rq.target_col)];
      end
      default: ;
    endcase
    res.cursor_row = row_q;
    res.cursor_col = col_q;
    return res;
  endfunction

  // Track register writes, compare results, then queue the new request's result
  always @(posedge clk) begin : watch
    out_item_t want;
    int        i;
    if (!rst_n) begin
      for (i = 0; i < CELLS; i++) screen_mem[i] = '0;
      row_q   = '0;
      col_q   = '0;
      attr_q  = ATTR_RESET;
      blank_q = BLANK_RESET;
      awaited_results.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEXT_ATTR:  attr_q  = cfg_wdata[ATTR_W-1:0];
          CFG_BLANK_CELL: blank_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          if (fails < 10)
            $display("%0t: result with none awaited: row=%0d col=%0d cell=%h",
                     $time, out_item.cursor_row, out_item.cursor_col, out_item.cell_data);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.cursor_row !== want.cursor_row ||
              out_item.cursor_col !== want.cursor_col ||
              out_item.cell_data  !== want.cell_data) begin
            if (fails < 10)
              $display("%0t: mismatch: expected row=%0d col=%0d cell=%h, got row=%0d col=%0d cell=%h",
                       $time, want.cursor_row, want.cursor_col, want.cell_data,
                       out_item.cursor_row, out_item.cursor_col, out_item.cell_data);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(console_step(in_item));
    end
    fail_count <= fails;
    pending    <= awaited_results.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import tcs_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int PHASES           = 5;
  localparam int PHASE_ITEMS      = 200;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT      = 20000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    quiet_cycles;
  bit                    tx_idling;
  bit                    rx_idling;
  bit                    long_hold_req;

  always #5 clk = ~clk;

  text_console_cursor_scroll_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tcs_console_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one request, with an occasional idle burst ahead of it
  task automatic send_request(input in_item_t rq);
    int gap;
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                         input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    in_item_t rq;
    rq.op         = op;
    rq.char_code  = ch;
    rq.target_row = r;
    rq.target_col = c;
    send_request(rq);
  endtask

  // Hold the sender until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly printing, with cursor moves biased toward the bottom line to force scrolls
  function automatic in_item_t random_request();
    in_item_t rq;
    int       pick;
    rq.char_code  = CHAR_W'($urandom);
    rq.target_row = ROW_W'($urandom);
    rq.target_col = COL_W'($urandom);
    case ($urandom_range(0, 7))
      0: ;
      1, 2: begin
        rq.target_row = LAST_ROW;
        rq.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
      end
      default: begin
        rq.target_row = ROW_W'($urandom_range(0, ROWS - 1));
        rq.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 55)      rq.op = OP_PRINT;
    else if (pick < 66) rq.op = OP_NEWLINE;
    else if (pick < 76) rq.op = OP_BACKSPACE;
    else if (pick < 78) rq.op = OP_FILL;
    else if (pick < 88) rq.op = OP_SET_CURSOR;
    else if (pick < 97) rq.op = OP_READ_CELL;
    else                rq.op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
    return rq;
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** text_console_cursor_scroll_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int                    ph;
    int                    n;
    logic [CFG_DATA_W-1:0] attr_word;
    logic [CFG_DATA_W-1:0] blank_word;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    tx_idling     = 1'b1;
    rx_idling     = 1'b1;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values
    send_op(OP_READ_CELL,  8'h00, 5'd0,  7'd0);
    send_op(OP_PRINT,      8'h00, 5'd0,  7'd0);
    send_op(OP_PRINT,      8'hFF, 5'd0,  7'd0);
    send_op(OP_BACKSPACE,  8'h00, 5'd0,  7'd0);
    send_op(OP_SET_CURSOR, 8'h00, 5'd0,  7'd0);
    // backspace at the top-left corner only restores the cell
    send_op(OP_BACKSPACE,  8'h00, 5'd0,  7'd0);
    // out-of-range cursor saturates to the bottom-right corner
    send_op(OP_SET_CURSOR, 8'h00, 5'd31, 7'd127);
    // print at the last cell wraps and scrolls
    send_op(OP_PRINT,      8'h41, 5'd0,  7'd0);
    send_op(OP_READ_CELL,  8'h00, 5'd23, 7'd79);
    send_op(OP_READ_CELL,  8'h00, 5'd24, 7'd79);
    send_op(OP_NEWLINE,    8'hFF, 5'd0,  7'd0);
    send_op(OP_SET_CURSOR, 8'h00, 5'd10, 7'd0);
    // backspace at column zero crosses to the previous line end
    send_op(OP_BACKSPACE,  8'h00, 5'd0,  7'd0);
    send_op(OP_NEWLINE,    8'h00, 5'd0,  7'd0);
    send_op(OP_NEWLINE,    8'h00, 5'd0,  7'd0);
    // out-of-range reads return zero
    send_op(OP_READ_CELL,  8'h00, 5'd25, 7'd0);
    send_op(OP_READ_CELL,  8'h00, 5'd0,  7'd80);
    send_op(OP_READ_CELL,  8'h00, 5'd31, 7'd127);
    send_op(OP_FILL,       8'hA5, 5'd0,  7'd0);
    send_op(OP_READ_CELL,  8'h00, 5'd12, 7'd40);
    send_op(OP_SPARE_6,    8'h55, 5'd3,  7'd3);
    send_op(OP_SPARE_7,    8'hAA, 5'd7,  7'd7);
    send_op(OP_SET_CURSOR, 8'h00, 5'd5,  7'd127);
    send_op(OP_READ_CELL,  8'h00, 5'd24, 7'd0);

    // Random part, one register setting per phase
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          attr_word  = 16'h0000;
          blank_word = 16'h0000;
        end
        1: begin
          attr_word  = 16'hFFFF;
          blank_word = 16'hFFFF;
        end
        3: begin
          attr_word  = 16'h0007;
          blank_word = 16'h0720;
        end
        default: begin
          attr_word  = CFG_DATA_W'($urandom);
          blank_word = CFG_DATA_W'($urandom);
        end
      endcase
      cfg_write(CFG_TEXT_ATTR, attr_word);
      cfg_write(CFG_BLANK_CELL, blank_word);
      if (ph == PHASES - 1) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // stall the receiver for a long stretch while requests keep coming
        if (ph == 1 && n == 40) long_hold_req = 1'b1;
        send_request(random_request());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("** text_console_cursor_scroll_top: PASSED **");
    else
      $display("** text_console_cursor_scroll_top: FAILED **");
    $finish;
  end

endmodule
